>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros shared by the interpolator rtl, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// clocked check with explicit clock and active-low reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: check failed");
// clocked check on the module's clk_i and rst_ni
`define ASSERT_CHECK(lbl, prop) `ASSERT_CLK(lbl, clk_i, rst_ni, prop)
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_CHECK(lbl, prop)
`endif
`endif

>>> sv/lfi_pkg.sv
// ----------------------------------------------------------------------------
// lfi_pkg
// shared widths, filter coefficients and register codes
// ----------------------------------------------------------------------------
package lfi_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int PRED_W     = 16;
  localparam int CNT_W      = 7;
  localparam int FRAC_W     = 2;
  localparam int DEPTH_W    = 4;
  localparam int SHIFT_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  localparam int TAPS       = 8;
  localparam int LINES      = TAPS - 1;
  localparam int SLOT_W     = $clog2(LINES);
  localparam int CENTER_TAP = TAPS / 2 - 1;

  // horizontal sum of unsigned samples, vertical sum of 16-bit values
  localparam int HSUM_W = 20;
  localparam int VSUM_W = 24;

  localparam int INTERNAL_DEPTH = 14;
  localparam int SEP_SHIFT      = 6;
  localparam int MIN_BLOCK      = 4;
  localparam int DEF_MAX_BLOCK  = 64;
  localparam int MIN_DEPTH      = 8;
  localparam int MAX_DEPTH      = 12;
  localparam int RESET_BLOCK    = 8;
  localparam int RESET_DEPTH    = 8;

  localparam logic [FRAC_W-1:0] FRAC_FULL = 2'd0;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAC_X       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAC_Y       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_DEPTH    = 3'd4;

  typedef logic signed [7:0] coef_t;

  localparam coef_t LUMA_TAPS [4][TAPS] = '{
    '{ 8'sd0,  8'sd0,   8'sd0, 8'sd64,  8'sd0,   8'sd0,  8'sd0,  8'sd0 },
    '{-8'sd1,  8'sd4, -8'sd10, 8'sd58, 8'sd17,  -8'sd5,  8'sd1,  8'sd0 },
    '{-8'sd1,  8'sd4, -8'sd11, 8'sd40, 8'sd40, -8'sd11,  8'sd4, -8'sd1 },
    '{ 8'sd0,  8'sd1,  -8'sd5, 8'sd17, 8'sd58, -8'sd10,  8'sd4, -8'sd1 }
  };

  typedef struct packed {
    logic [FRAC_W-1:0]  frac_x;
    logic [FRAC_W-1:0]  frac_y;
    logic [SHIFT_W-1:0] shift1;
    logic [SHIFT_W-1:0] shift3;
  } filt_ctrl_t;

endpackage

>>> sv/lfi_ram.sv
// ----------------------------------------------------------------------------
// lfi_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module lfi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 72,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/lfi_hfilt.sv
// ----------------------------------------------------------------------------
// lfi_hfilt
// horizontal 8-tap luma filter over one window row, or full-pel pass
// ----------------------------------------------------------------------------
module lfi_hfilt
  import lfi_pkg::*;
(
  input  logic [SAMPLE_W-1:0] win_i [TAPS],
  input  filt_ctrl_t          ctrl_i,
  output logic [PRED_W-1:0]   cur_o
);

  logic signed [HSUM_W-1:0] sum;
  logic signed [HSUM_W-1:0] sum_sh;

  always_comb begin
    sum = '0;
    for (int k = 0; k < TAPS; k++) begin
      sum = sum + HSUM_W'(LUMA_TAPS[ctrl_i.frac_x][k])
                * $signed({{(HSUM_W - SAMPLE_W){1'b0}}, win_i[k]});
    end
    sum_sh = sum >>> ctrl_i.shift1;
    if (ctrl_i.frac_x != FRAC_FULL) begin
      cur_o = sum_sh[PRED_W-1:0];
    end else begin
      cur_o = {{(PRED_W - SAMPLE_W){1'b0}}, win_i[CENTER_TAP]};
    end
  end

endmodule

>>> sv/lfi_vfilt.sv
// ----------------------------------------------------------------------------
// lfi_vfilt
// vertical 8-tap luma filter over one column and final scaling
// ----------------------------------------------------------------------------
module lfi_vfilt
  import lfi_pkg::*;
(
  input  logic signed [PRED_W-1:0] colv_i [TAPS],
  input  filt_ctrl_t               ctrl_i,
  output logic [PRED_W-1:0]        pred_o
);

  logic signed [VSUM_W-1:0] sum;
  logic signed [VSUM_W-1:0] sum_sh;
  logic [SHIFT_W-1:0]       vshift;
  logic [PRED_W-1:0]        full_pel;

  always_comb begin
    sum = '0;
    for (int k = 0; k < TAPS; k++) begin
      sum = sum + VSUM_W'(LUMA_TAPS[ctrl_i.frac_y][k]) * VSUM_W'(colv_i[k]);
    end
    // vertical-only drops bitdepth-8, separable drops the fixed 6
    vshift   = (ctrl_i.frac_x == FRAC_FULL) ? ctrl_i.shift1 : SHIFT_W'(SEP_SHIFT);
    sum_sh   = sum >>> vshift;
    full_pel = colv_i[CENTER_TAP] << ctrl_i.shift3;
    if (ctrl_i.frac_y != FRAC_FULL) begin
      pred_o = sum_sh[PRED_W-1:0];
    end else if (ctrl_i.frac_x == FRAC_FULL) begin
      pred_o = full_pel;
    end else begin
      pred_o = colv_i[CENTER_TAP];
    end
  end

endmodule

>>> sv/luma_fractional_interpolator.sv
// ----------------------------------------------------------------------------
// luma_fractional_interpolator
// pipeline: a window sample passes the input register, horizontal filter,
// column register, vertical filter and output register; throughput: one
// window sample per cycle while not stalled, set by one line store port pair
// reset: counters, row shift and config clear at once; line store is not
// cleared and needs no sweep, so samples are taken right after reset
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module luma_fractional_interpolator
  import lfi_pkg::*;
#(
  parameter int MAX_BLOCK = DEF_MAX_BLOCK
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // reference window stream
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [SAMPLE_W-1:0]   ref_sample_i,
  input  logic                  block_start_i,
  // prediction stream
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PRED_W-1:0]     pred_sample_o,
  output logic                  last_o
);

  // line store holds seven rows, one column per window column past the filter
  localparam int STORE_COLS = MAX_BLOCK + TAPS;
  localparam int ADDR_W     = $clog2(STORE_COLS);

  // --------------------------------------------------------------------------
  // configuration registers, clamped into their legal ranges for use
  // --------------------------------------------------------------------------
  logic [FRAC_W-1:0]  frac_x_q, frac_y_q;
  logic [CNT_W-1:0]   block_width_q, block_height_q;
  logic [DEPTH_W-1:0] bit_depth_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_x_q       <= FRAC_FULL;
      frac_y_q       <= FRAC_FULL;
      block_width_q  <= CNT_W'(RESET_BLOCK);
      block_height_q <= CNT_W'(RESET_BLOCK);
      bit_depth_q    <= DEPTH_W'(RESET_DEPTH);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FRAC_X:       frac_x_q       <= cfg_wdata_i[FRAC_W-1:0];
        REG_FRAC_Y:       frac_y_q       <= cfg_wdata_i[FRAC_W-1:0];
        REG_BLOCK_WIDTH:  block_width_q  <= cfg_wdata_i[CNT_W-1:0];
        REG_BLOCK_HEIGHT: block_height_q <= cfg_wdata_i[CNT_W-1:0];
        REG_BIT_DEPTH:    bit_depth_q    <= cfg_wdata_i[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CNT_W-1:0]   blk_w, blk_h;
  logic [DEPTH_W-1:0] depth;
  filt_ctrl_t         ctrl;

  always_comb begin
    if (block_width_q < CNT_W'(MIN_BLOCK)) begin
      blk_w = CNT_W'(MIN_BLOCK);
    end else if (block_width_q > CNT_W'(MAX_BLOCK)) begin
      blk_w = CNT_W'(MAX_BLOCK);
    end else begin
      blk_w = block_width_q;
    end
    if (block_height_q < CNT_W'(MIN_BLOCK)) begin
      blk_h = CNT_W'(MIN_BLOCK);
    end else if (block_height_q > CNT_W'(MAX_BLOCK)) begin
      blk_h = CNT_W'(MAX_BLOCK);
    end else begin
      blk_h = block_height_q;
    end
    if (bit_depth_q < DEPTH_W'(MIN_DEPTH)) begin
      depth = DEPTH_W'(MIN_DEPTH);
    end else if (bit_depth_q > DEPTH_W'(MAX_DEPTH)) begin
      depth = DEPTH_W'(MAX_DEPTH);
    end else begin
      depth = bit_depth_q;
    end
    ctrl.frac_x = frac_x_q;
    ctrl.frac_y = frac_y_q;
    ctrl.shift1 = SHIFT_W'(depth - DEPTH_W'(MIN_DEPTH));
    ctrl.shift3 = SHIFT_W'(DEPTH_W'(INTERNAL_DEPTH) - depth);
  end

  // --------------------------------------------------------------------------
  // pipeline advance: everything moves unless the output holds a stalled item
  // --------------------------------------------------------------------------
  logic out_valid_q;
  logic en;
  logic accept;

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;
  assign accept     = in_valid_i && en;

  // --------------------------------------------------------------------------
  // window position counters; slot tracks row mod seven
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0]  col_q, row_q;
  logic [SLOT_W-1:0] slot_q;
  logic [CNT_W-1:0]  col_cur, row_cur, col_d, row_d;
  logic [SLOT_W-1:0] slot_cur, slot_d;
  logic [CNT_W:0]    col_inc, row_inc;
  logic              col_wrap, row_wrap;
  logic [CNT_W-1:0]  col_i, row_j;
  logic              has_col, has_row;
  logic              in_store, produce, is_last;

  always_comb begin
    // block start forces the position back to the window origin
    col_cur  = block_start_i ? '0 : col_q;
    row_cur  = block_start_i ? '0 : row_q;
    slot_cur = block_start_i ? '0 : slot_q;

    col_inc  = {1'b0, col_cur} + (CNT_W + 1)'(1);
    row_inc  = {1'b0, row_cur} + (CNT_W + 1)'(1);
    col_wrap = col_inc >= ({1'b0, blk_w} + (CNT_W + 1)'(LINES));
    row_wrap = row_inc >= ({1'b0, blk_h} + (CNT_W + 1)'(LINES));

    col_d  = col_wrap ? '0 : col_inc[CNT_W-1:0];
    row_d  = row_cur;
    slot_d = slot_cur;
    if (col_wrap) begin
      if (row_wrap) begin
        row_d  = '0;
        slot_d = '0;
      end else begin
        row_d  = row_inc[CNT_W-1:0];
        slot_d = (slot_cur == SLOT_W'(LINES - 1)) ? '0 : slot_cur + SLOT_W'(1);
      end
    end

    has_col  = col_cur >= CNT_W'(LINES);
    has_row  = row_cur >= CNT_W'(LINES);
    col_i    = col_cur - CNT_W'(LINES);
    row_j    = row_cur - CNT_W'(LINES);
    in_store = has_col && (col_i < CNT_W'(STORE_COLS));
    produce  = has_col && has_row && (col_i < blk_w) && (row_j < blk_h);
    is_last  = (row_j == blk_h - CNT_W'(1)) && (col_i == blk_w - CNT_W'(1));
  end

  logic [SAMPLE_W-1:0] row_shift_q [LINES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= '0;
      for (int k = 0; k < LINES; k++) begin
        row_shift_q[k] <= '0;
      end
    end else if (accept) begin
      col_q  <= col_d;
      row_q  <= row_d;
      slot_q <= slot_d;
      for (int k = 0; k < LINES - 1; k++) begin
        row_shift_q[k] <= row_shift_q[k+1];
      end
      row_shift_q[LINES-1] <= ref_sample_i;
    end
  end

  // --------------------------------------------------------------------------
  // line store: one ram per row slot, all read at the current column
  // --------------------------------------------------------------------------
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [LINES-1:0]  ram_we;
  logic [PRED_W-1:0] ram_rdata [LINES];
  logic [PRED_W-1:0] s1_cur;

  logic                s1_valid_q;
  logic [SAMPLE_W-1:0] s1_win_q [TAPS];
  logic [SLOT_W-1:0]   s1_slot_q;
  logic [ADDR_W-1:0]   s1_addr_q;
  logic                s1_store_q, s1_produce_q, s1_last_q;

  assign ram_re    = accept && in_store;
  assign ram_raddr = col_i[ADDR_W-1:0];

  for (genvar g = 0; g < LINES; g++) begin : g_line
    assign ram_we[g] = en && s1_valid_q && s1_store_q && (s1_slot_q == SLOT_W'(g));

    lfi_ram #(
      .WIDTH (PRED_W),
      .DEPTH (STORE_COLS)
    ) u_line_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we[g]),
      .waddr_i (s1_addr_q),
      .wdata_i (s1_cur),
      .re_i    (ram_re),
      .raddr_i (ram_raddr),
      .rdata_o (ram_rdata[g])
    );
  end

  // --------------------------------------------------------------------------
  // stage 1: input register, horizontal filter, line store write
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int k = 0; k < LINES; k++) begin
        s1_win_q[k] <= row_shift_q[k];
      end
      s1_win_q[TAPS-1] <= ref_sample_i;
      s1_slot_q        <= slot_cur;
      s1_addr_q        <= col_i[ADDR_W-1:0];
      s1_store_q       <= in_store;
      s1_produce_q     <= produce;
      s1_last_q        <= is_last;
    end
  end

  lfi_hfilt u_hfilt (
    .win_i  (s1_win_q),
    .ctrl_i (ctrl),
    .cur_o  (s1_cur)
  );

  // oldest row first: tap k comes from slot (row + k) mod seven
  logic signed [PRED_W-1:0] s1_colv [TAPS];

  always_comb begin
    logic [SLOT_W:0] rot_idx;
    rot_idx = '0;
    for (int k = 0; k < LINES; k++) begin
      rot_idx = {1'b0, s1_slot_q} + (SLOT_W + 1)'(k);
      if (rot_idx >= (SLOT_W + 1)'(LINES)) begin
        rot_idx = rot_idx - (SLOT_W + 1)'(LINES);
      end
      s1_colv[k] = ram_rdata[rot_idx[SLOT_W-1:0]];
    end
    s1_colv[TAPS-1] = s1_cur;
  end

  // --------------------------------------------------------------------------
  // stage 2: column register and vertical filter into the output register
  // --------------------------------------------------------------------------
  logic                     s2_valid_q;
  logic signed [PRED_W-1:0] s2_colv_q [TAPS];
  logic                     s2_last_q;
  logic [PRED_W-1:0]        pred_d;
  logic [PRED_W-1:0]        pred_q;
  logic                     last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q  <= s1_valid_q && s1_produce_q;
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_colv_q <= s1_colv;
      s2_last_q <= s1_last_q;
    end
    if (en && s2_valid_q) begin
      pred_q <= pred_d;
      last_q <= s2_last_q;
    end
  end

  lfi_vfilt u_vfilt (
    .colv_i (s2_colv_q),
    .ctrl_i (ctrl),
    .pred_o (pred_d)
  );

  assign out_valid_o   = out_valid_q;
  assign pred_sample_o = pred_q;
  assign last_o        = last_q;

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  // a column is never read in the same cycle the previous sample writes it
  `ASSERT_CHECK(a_no_rw_collision, (ram_re && (|ram_we)) |-> (ram_raddr != s1_addr_q))
  // row slot restarts together with the row counter
  `ASSERT_CHECK(a_slot_follows_row, (row_q == '0) |-> (slot_q == '0))
  // a new output only comes from a filled vertical stage
  `ASSERT_CHECK(a_out_from_stage2, $rose(out_valid_q) |-> $past(s2_valid_q))
  // a held output freezes the inner stages too
  `ASSERT_CHECK(a_stall_freezes, (!en) |=> ($stable(s1_valid_q) && $stable(s2_valid_q)))

endmodule
